// ===== sv/otwd_pkg.sv =====
package otwd_pkg;

    // fixed-point format of sine, power, offset and duty
    localparam int FRAC_BITS = 14;
    localparam int SIN_W     = FRAC_BITS + 2;     // signed sine, -1.0 .. +1.0
    localparam int PROD_W    = SIN_W + 16;        // sine times 16-bit power
    localparam int SHIFT_W   = PROD_W - FRAC_BITS;
    localparam int DRV_W     = SHIFT_W + 1;       // rounded product plus offset
    localparam int DUTY_W    = 15;
    localparam int DEG_W     = 9;
    localparam int QDEG_W    = 7;                 // 0 .. 90

    localparam logic [DEG_W-1:0] ANGLE_RIGHT = DEG_W'(60);
    localparam logic [DEG_W-1:0] ANGLE_BACK  = DEG_W'(180);
    localparam logic [DEG_W-1:0] ANGLE_LEFT  = DEG_W'(300);

    localparam longint unsigned PI_Q31  = 64'd6746518852;
    localparam longint unsigned ONE_Q31 = 64'd2147483648;

    typedef enum logic [1:0] {
        KIND_MOVE    = 2'd0,
        KIND_UNIFORM = 2'd1,
        KIND_BRAKE   = 2'd2,
        KIND_SPARE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic              a;
        logic              b;
        logic [DUTY_W-1:0] duty;
    } wheel_out_t;

    typedef logic [FRAC_BITS:0] sin_tbl_t [91];

    // first-quadrant sine per whole degree, odd series in Q31, rounded at FRAC_BITS
    function automatic sin_tbl_t build_sin_tbl();
        sin_tbl_t        tbl;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned p;
        longint unsigned s;
        longint          sum;
        for (int k = 0; k <= 90; k++) begin
            x   = (longint'(k) * PI_Q31 + 64'd90) / 64'd180;
            x2  = (x * x) >> 31;
            t   = x;
            sum = longint'(x);
            for (int i = 1; i <= 8; i++) begin
                p = (t * x2) >> 31;
                // divide by (2i)(2i+1)
                case (i)
                    1:       t = p / 64'd6;
                    2:       t = p / 64'd20;
                    3:       t = p / 64'd42;
                    4:       t = p / 64'd72;
                    5:       t = p / 64'd110;
                    6:       t = p / 64'd156;
                    7:       t = p / 64'd210;
                    default: t = p / 64'd272;
                endcase
                if ((i % 2) == 1) begin
                    sum = sum - longint'(t);
                end else begin
                    sum = sum + longint'(t);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            s = longint'(sum);
            if (s > ONE_Q31) begin
                s = ONE_Q31;
            end
            tbl[k] = (FRAC_BITS + 1)'((s + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS));
        end
        return tbl;
    endfunction

    localparam sin_tbl_t SIN_TBL = build_sin_tbl();

endpackage

// ===== sv/otwd_wheel.sv =====
module otwd_wheel (
    input  logic [1:0]                 kind,
    input  logic [otwd_pkg::DEG_W-1:0] heading,     // already reduced to 0..359
    input  logic [otwd_pkg::DEG_W-1:0] angle,
    input  logic signed [15:0]         power,
    input  logic signed [15:0]         offset,
    output otwd_pkg::wheel_out_t       wheel
);
    import otwd_pkg::*;

    logic [DEG_W:0]              diff;
    logic [DEG_W-1:0]            rel;
    logic [DEG_W-1:0]            half;
    logic                        neg;
    logic [QDEG_W-1:0]           qdeg;
    logic [FRAC_BITS:0]          sin_mag;
    logic signed [SIN_W-1:0]     sin_val;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W-1:0]    prod_rnd;
    logic signed [SHIFT_W-1:0]   prod_sh;
    logic signed [DRV_W-1:0]     drive;
    logic [DRV_W-1:0]            mag;

    always_comb begin
        // relative angle (heading - wheel) mod 360
        diff = {1'b0, heading} + (DEG_W+1)'(360) - {1'b0, angle};
        if (diff >= (DEG_W+1)'(360)) begin
            rel = DEG_W'(diff - (DEG_W+1)'(360));
        end else begin
            rel = diff[DEG_W-1:0];
        end

        // fold onto the first quadrant
        neg  = (rel >= DEG_W'(180));
        half = neg ? rel - DEG_W'(180) : rel;
        qdeg = (half <= DEG_W'(90)) ? half[QDEG_W-1:0] : QDEG_W'(DEG_W'(180) - half);

        sin_mag = SIN_TBL[qdeg];
        sin_val = neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});

        prod     = sin_val * power;
        // round to nearest, ties toward plus infinity (arithmetic shift floors)
        prod_rnd = prod + PROD_W'(1 << (FRAC_BITS - 1));
        prod_sh  = SHIFT_W'(prod_rnd >>> FRAC_BITS);

        if (kind == KIND_UNIFORM) begin
            drive = DRV_W'(offset);
        end else begin
            drive = DRV_W'(prod_sh) + DRV_W'(offset);
        end

        mag = drive[DRV_W-1] ? DRV_W'(-drive) : DRV_W'(drive);

        if (kind[1]) begin
            wheel.a    = 1'b1;
            wheel.b    = 1'b1;
            wheel.duty = '0;
        end else begin
            wheel.a = drive[DRV_W-1];
            wheel.b = !drive[DRV_W-1] && (drive != '0);
            if (mag > DRV_W'(1 << FRAC_BITS)) begin
                wheel.duty = DUTY_W'(1 << FRAC_BITS);
            end else begin
                wheel.duty = DUTY_W'(mag);
            end
        end
    end

endmodule

// ===== sv/omni_three_wheel_drive_unit.sv =====
// Stages: input register, then result register holding the three wheel drives.
// Throughput: one command per cycle; the result register and the input
// register advance together whenever the result side is taken or empty.
// Reset: aresetn is synchronous, active low, and empties both stages.
module omni_three_wheel_drive_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // heading_deg[8:0], power[24:9], offset[40:25], zero
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // right_a[0], right_b[1], right_duty[16:2], back_a[17], back_b[18],
    // back_duty[33:19], left_a[34], left_b[35], left_duty[50:36], zero
    output logic [55:0] m_tdata
);
    import otwd_pkg::*;

    logic                in_vld_reg;
    logic                in_vld_next;
    logic [1:0]          kind_reg;
    logic [DEG_W-1:0]    heading_reg;
    logic signed [15:0]  power_reg;
    logic signed [15:0]  offset_reg;
    logic                out_vld_reg;
    logic                out_vld_next;
    logic [55:0]         out_data_reg;

    logic                out_adv;
    logic                in_adv;
    logic [DEG_W-1:0]    heading_raw;
    logic [DEG_W-1:0]    heading_mod;
    wheel_out_t          right_w;
    wheel_out_t          back_w;
    wheel_out_t          left_w;

    assign out_adv  = !out_vld_reg || m_tready;
    assign in_adv   = out_adv;
    assign s_tready = !in_vld_reg || in_adv;

    always_comb begin
        in_vld_next  = s_tready ? s_tvalid : in_vld_reg;
        out_vld_next = out_adv ? in_vld_reg : out_vld_reg;
    end

    // take the heading modulo 360 at the input
    assign heading_raw = s_tdata[8:0];
    assign heading_mod = (heading_raw >= DEG_W'(360)) ? heading_raw - DEG_W'(360) : heading_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            kind_reg    <= s_tuser;
            heading_reg <= heading_mod;
            power_reg   <= s_tdata[24:9];
            offset_reg  <= s_tdata[40:25];
        end
        if (out_adv && in_vld_reg) begin
            out_data_reg <= {5'd0, left_w.duty, left_w.b, left_w.a,
                             back_w.duty, back_w.b, back_w.a,
                             right_w.duty, right_w.b, right_w.a};
        end
    end

    otwd_wheel u_right (
        .kind    (kind_reg),
        .heading (heading_reg),
        .angle   (ANGLE_RIGHT),
        .power   (power_reg),
        .offset  (offset_reg),
        .wheel   (right_w)
    );

    otwd_wheel u_back (
        .kind    (kind_reg),
        .heading (heading_reg),
        .angle   (ANGLE_BACK),
        .power   (power_reg),
        .offset  (offset_reg),
        .wheel   (back_w)
    );

    otwd_wheel u_left (
        .kind    (kind_reg),
        .heading (heading_reg),
        .angle   (ANGLE_LEFT),
        .power   (power_reg),
        .offset  (offset_reg),
        .wheel   (left_w)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== tb/wheel_drive_monitor.sv =====
`timescale 1ns / 100ps

module wheel_drive_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // heading_deg[8:0], power[24:9], offset[40:25], zero
    input  logic [1:0]  s_tuser,   // kind[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    // right_a[0], right_b[1], right_duty[16:2], back_a[17], back_b[18],
    // back_duty[33:19], left_a[34], left_b[35], left_duty[50:36], zero
    input  logic [55:0] m_tdata,
    output int          err_count,
    output int          cmds_seen,
    output int          drives_checked
);
    import otwd_pkg::*;

    localparam int WHEEL_W = DUTY_W + 2;

    logic [55:0] expected_drives [$];

    initial begin
        err_count      = 0;
        cmds_seen      = 0;
        drives_checked = 0;
    end

    // sine of a whole degree (0..359) with FRAC_BITS fraction bits
    function automatic longint sine_of_degree(int unsigned deg);
        int unsigned     q;
        int unsigned     k;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          sum;
        longint          r;
        q = deg % 180;
        k = (q <= 90) ? q : 180 - q;
        x = (64'(k) * PI_Q31 + 64'd90) / 64'd180;
        x2 = (x * x) >> 31;
        t = x;
        sum = longint'(x);
        // odd Taylor terms, alternating sign
        for (int i = 1; i <= 8; i++) begin
            t = ((t * x2) >> 31) / 64'((2 * i) * (2 * i + 1));
            if (i % 2 == 1) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (64'(sum) > ONE_Q31) begin
            sum = longint'(ONE_Q31);
        end
        r = longint'((64'(sum) + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS));
        return (deg >= 180) ? -r : r;
    endfunction

    // bridge pins and saturated duty: {duty, b, a}
    function automatic logic [WHEEL_W-1:0] bridge_for(longint drv);
        logic            pin_a;
        logic            pin_b;
        longint          mag;
        pin_a = 1'b0;
        pin_b = 1'b0;
        mag   = 0;
        if (drv < 0) begin
            pin_a = 1'b1;
            mag   = -drv;
        end else if (drv > 0) begin
            pin_b = 1'b1;
            mag   = drv;
        end
        if (mag > (longint'(1) << FRAC_BITS)) begin
            mag = longint'(1) << FRAC_BITS;
        end
        return {DUTY_W'(mag), pin_b, pin_a};
    endfunction

    function automatic logic [55:0] wheel_drives(kind_t k, logic [8:0] hdg_raw,
                                                 logic [15:0] pwr, logic [15:0] ofs);
        logic [8:0]  angles [3];
        logic [55:0] word;
        int unsigned hdg;
        int unsigned rel;
        longint      prod;
        longint      drv;
        angles[0] = ANGLE_RIGHT;
        angles[1] = ANGLE_BACK;
        angles[2] = ANGLE_LEFT;
        word = '0;
        hdg = int'(hdg_raw) % 360;
        for (int w = 0; w < 3; w++) begin
            if (k == KIND_MOVE) begin
                rel  = (hdg + 360 - int'(angles[w])) % 360;
                prod = sine_of_degree(rel) * longint'($signed(pwr));
                // round to nearest, ties upward, then add the spin offset
                drv  = ((prod + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS)
                       + longint'($signed(ofs));
                word[WHEEL_W*w +: WHEEL_W] = bridge_for(drv);
            end else if (k == KIND_UNIFORM) begin
                word[WHEEL_W*w +: WHEEL_W] = bridge_for(longint'($signed(ofs)));
            end else begin
                word[WHEEL_W*w +: WHEEL_W] = {DUTY_W'(0), 1'b1, 1'b1};
            end
        end
        return word;
    endfunction

    task automatic flag_mismatch(string what, longint exp_v, longint act_v);
        err_count++;
        if (err_count <= 10) begin
            $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        logic [55:0] exp_word;
        string       wheel_names [3];
        wheel_names[0] = "right";
        wheel_names[1] = "back";
        wheel_names[2] = "left";
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_drives.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("[%0t] MISMATCH: result 0x%014h with no command outstanding",
                                 $time, m_tdata);
                    end
                end else begin
                    exp_word = expected_drives.pop_front();
                    drives_checked++;
                    for (int w = 0; w < 3; w++) begin
                        if (m_tdata[WHEEL_W*w] !== exp_word[WHEEL_W*w]) begin
                            flag_mismatch({wheel_names[w], "_a"}, exp_word[WHEEL_W*w],
                                          m_tdata[WHEEL_W*w]);
                        end
                        if (m_tdata[WHEEL_W*w+1] !== exp_word[WHEEL_W*w+1]) begin
                            flag_mismatch({wheel_names[w], "_b"}, exp_word[WHEEL_W*w+1],
                                          m_tdata[WHEEL_W*w+1]);
                        end
                        if (m_tdata[WHEEL_W*w+2 +: DUTY_W] !== exp_word[WHEEL_W*w+2 +: DUTY_W])
                        begin
                            flag_mismatch({wheel_names[w], "_duty"},
                                          exp_word[WHEEL_W*w+2 +: DUTY_W],
                                          m_tdata[WHEEL_W*w+2 +: DUTY_W]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_drives.push_back(wheel_drives(kind_t'(s_tuser), s_tdata[8:0],
                                                       s_tdata[24:9], s_tdata[40:25]));
                cmds_seen++;
            end
        end
    end

endmodule

// ===== tb/omni_three_wheel_drive_unit_tb.sv =====
`timescale 1ns / 100ps

module omni_three_wheel_drive_unit_tb;
    import otwd_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    int err_count;
    int cmds_seen;
    int drives_checked;

    int burst_left = 8;
    int n_move     = 0;
    int n_uniform  = 0;
    int n_brake    = 0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;

    localparam int LONG_HOLD = 400;

    omni_three_wheel_drive_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    wheel_drive_monitor mon (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .err_count      (err_count),
        .cmds_seen      (cmds_seen),
        .drives_checked (drives_checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // offer one command, hold it until taken, then pace bursts and gaps
    task automatic issue_command(input kind_t k, input logic [8:0] hdg,
                                 input logic [15:0] pwr, input logic [15:0] ofs);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {7'd0, ofs, pwr, hdg};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (k)
            KIND_MOVE:    n_move++;
            KIND_UNIFORM: n_uniform++;
            default:      n_brake++;
        endcase
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    function automatic logic [15:0] pick_power();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 16'($urandom);
        end else if (r < 85) begin
            return 16'($urandom_range(0, 2048)) - 16'd1024;
        end
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h4000;
            default: return 16'hC000;
        endcase
    endfunction

    function automatic logic [15:0] pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return 16'($urandom);
        end else if (r < 70) begin
            return 16'($urandom_range(0, 1024)) - 16'd512;
        end else if (r < 90) begin
            return 16'd0;
        end
        return ($urandom_range(0, 1) == 1) ? 16'h4001 : 16'hBFFF;
    endfunction

    // result side: stretches of differing stall patterns, one long hold-off
    initial begin : result_sink
        int   stretch;
        int   mode;
        logic rdy;
        stretch = 0;
        mode    = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end
            if (stretch == 0) begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(20, 150);
            end
            stretch--;
            case (mode)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = ($urandom_range(0, 7) != 0);
                default: rdy = ($urandom_range(0, 3) == 0);
            endcase
            m_tready <= rdy;
        end
    end

    initial begin : stimulus
        kind_t       k;
        logic [8:0]  hdg;
        int          r;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: quadrant edges, heading wrap, rounding ties, saturation
        issue_command(KIND_MOVE, 9'd0,   16'h4000, 16'h0000);
        issue_command(KIND_MOVE, 9'd90,  16'h4000, 16'h0000);
        issue_command(KIND_MOVE, 9'd90,  16'h0001, 16'h0000);
        issue_command(KIND_MOVE, 9'd90,  16'hFFFF, 16'h0000);
        issue_command(KIND_MOVE, 9'd359, 16'h8000, 16'h0000);
        issue_command(KIND_MOVE, 9'd360, 16'h7FFF, 16'h0000);
        issue_command(KIND_MOVE, 9'd511, 16'hFFFF, 16'h0000);
        issue_command(KIND_MOVE, 9'd30,  16'h7FFF, 16'h7FFF);
        issue_command(KIND_MOVE, 9'd150, 16'h8000, 16'h8000);
        issue_command(KIND_MOVE, 9'd240, 16'h0000, 16'h0000);
        issue_command(KIND_MOVE, 9'd60,  16'h4000, 16'h0000);
        issue_command(KIND_MOVE, 9'd270, 16'h2000, 16'hF000);
        issue_command(KIND_UNIFORM, 9'd45,  16'h1234, 16'h0000);
        issue_command(KIND_UNIFORM, 9'd200, 16'h8000, 16'h4000);
        issue_command(KIND_UNIFORM, 9'd511, 16'h7FFF, 16'h4001);
        issue_command(KIND_UNIFORM, 9'd0,   16'h0000, 16'h8000);
        issue_command(KIND_UNIFORM, 9'd10,  16'hFFFF, 16'h7FFF);
        issue_command(KIND_UNIFORM, 9'd99,  16'h0001, 16'hFFFF);
        issue_command(KIND_BRAKE, 9'd123, 16'h7FFF, 16'h7FFF);
        issue_command(KIND_BRAKE, 9'd511, 16'h8000, 16'h8000);
        issue_command(KIND_SPARE, 9'd77,  16'h4000, 16'hC000);
        issue_command(KIND_SPARE, 9'd0,   16'h0000, 16'h0000);

        for (int n = 0; n < 1400; n++) begin
            if (n == 200) begin
                hold_req = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                k = KIND_MOVE;
            end else if (r < 85) begin
                k = KIND_UNIFORM;
            end else if (r < 95) begin
                k = KIND_BRAKE;
            end else begin
                k = KIND_SPARE;
            end
            if ($urandom_range(0, 99) < 85) begin
                hdg = 9'($urandom_range(0, 359));
            end else begin
                hdg = 9'($urandom_range(360, 511));
            end
            issue_command(k, hdg, pick_power(), pick_offset());
        end
        s_tvalid <= 1'b0;

        // drain, then wait for anything stray
        while (drives_checked != cmds_seen) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Covered %0d commands: %0d moves, %0d uniform, %0d brake or spare kind",
                 cmds_seen, n_move, n_uniform, n_brake);
        $display("Compared %0d results, including a %0d-cycle output stall with back-pressure",
                 drives_checked, LONG_HOLD);
        if (err_count == 0 && drives_checked == cmds_seen) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
